[sv/tio_pkg.sv]
// Package for the trigger pin channel: register map, mode, type,
// response and condition codes, and the timer constants.
// No dependencies.
package tio_pkg;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_CHANNEL_MODE      = 3'd0;
  localparam logic [2:0] REG_INPUT_TYPE        = 3'd1;
  localparam logic [2:0] REG_INPUT_SENSITIVITY = 3'd2;
  localparam logic [2:0] REG_INPUT_RESPONSE    = 3'd3;
  localparam logic [2:0] REG_OUTPUT_CONDITION  = 3'd4;
  localparam logic [2:0] REG_OUTPUT_POLARITY   = 3'd5;
  localparam logic [2:0] REG_COMPARE_THRESHOLD = 3'd6;

  // Channel modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_INPUT  = 2'd1;
  localparam logic [1:0] MODE_OUTPUT = 2'd2;

  // Input qualification types
  localparam logic [1:0] TYPE_RISING  = 2'd0;
  localparam logic [1:0] TYPE_FALLING = 2'd1;
  localparam logic [1:0] TYPE_HIGH    = 2'd2;
  localparam logic [1:0] TYPE_LOW     = 2'd3;

  // Sensitivity codes
  localparam logic [1:0] SENS_HIGH = 2'd0;
  localparam logic [1:0] SENS_MID  = 2'd1;

  // Response codes
  localparam logic [2:0] RESP_ON         = 3'd0;
  localparam logic [2:0] RESP_TOGGLE     = 3'd2;
  localparam logic [2:0] RESP_DELAY_STOP = 3'd6;

  // Output conditions
  localparam logic [3:0] COND_SUPPLY_OFF = 4'd0;
  localparam logic [3:0] COND_SUPPLY_ON  = 4'd1;
  localparam logic [3:0] COND_V_GT       = 4'd2;
  localparam logic [3:0] COND_V_LT       = 4'd3;
  localparam logic [3:0] COND_V_EQ       = 4'd4;
  localparam logic [3:0] COND_I_LT       = 4'd5;
  localparam logic [3:0] COND_I_GT       = 4'd6;
  localparam logic [3:0] COND_I_EQ       = 4'd7;
  localparam logic [3:0] COND_P_LT       = 4'd8;
  localparam logic [3:0] COND_P_GT       = 4'd9;
  localparam logic [3:0] COND_P_EQ       = 4'd10;

  // Sample periods in milliseconds
  localparam logic [16:0] HIGH_SENS_MS = 17'd10;
  localparam logic [16:0] MID_SENS_MS  = 17'd50;
  localparam logic [16:0] LOW_SENS_MS  = 17'd100;

  // Timer and level reset values
  localparam logic [16:0] TIMER_RESET   = 17'h0ffff;
  localparam logic [1:0]  LEVEL_UNKNOWN = 2'd3;

  // Input fields after the input register
  typedef struct packed {
    logic [31:0] measured_power;
    logic [31:0] measured_current;
    logic [31:0] measured_voltage;
    logic        supply_on;
    logic        pin_level;
    logic [15:0] tick_ms;
  } tick_t;

  // Result fields
  typedef struct packed {
    logic       supply_target;
    logic [2:0] action_code;
    logic       action_valid;
    logic       drive_level;
    logic       drive_valid;
  } result_t;

endpackage

[sv/trigger_io_channel.sv]
// Trigger pin channel top level: input register, tick evaluation and
// result register, plus the APB register file.
// Depends on tio_pkg.

// Each tick request yields exactly one result. A request passes through an
// input register and then a result register, which presents the result to
// the output port; one tick is taken every cycle while the result side
// keeps up; the sample timer and last pin level update in the same cycle the
// tick moves into the result register. The result register decouples the
// sides: a new tick is taken while a result waits, and the input stalls only
// while both registers are full and the result is not taken. In trigger-input
// mode the timer counts down by tick_ms and, once below zero, qualifies the
// pin and reloads by the sensitivity; in trigger-output mode the drive level
// follows the selected condition. Registers are at byte addresses 0 to 24
// in steps of 4 and must be written only while no tick is in flight.
module trigger_io_channel import tio_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Tick requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] tick_ms, [16] pin_level, [17] supply_on, [49:18] measured_voltage,
  // [81:50] measured_current, [113:82] measured_power, [119:114] zero
  input  logic [119:0] s_axis_tdata,
  // Results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] drive_valid, [1] drive_level, [2] action_valid, [5:3] action_code,
  // [6] supply_target, [7] zero
  output logic [7:0]   m_axis_tdata,
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Configuration registers
  logic [1:0]  channel_mode_q;
  logic [1:0]  input_type_q;
  logic [1:0]  input_sensitivity_q;
  logic [2:0]  input_response_q;
  logic [3:0]  output_condition_q;
  logic        output_polarity_q;
  logic [31:0] compare_threshold_q;

  logic [2:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_mode_q      <= MODE_INPUT;
      input_type_q        <= TYPE_RISING;
      input_sensitivity_q <= SENS_HIGH;
      input_response_q    <= RESP_ON;
      output_condition_q  <= COND_SUPPLY_OFF;
      output_polarity_q   <= 1'b1;
      compare_threshold_q <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_CHANNEL_MODE:      channel_mode_q      <= pwdata[1:0];
        REG_INPUT_TYPE:        input_type_q        <= pwdata[1:0];
        REG_INPUT_SENSITIVITY: input_sensitivity_q <= pwdata[1:0];
        REG_INPUT_RESPONSE:    input_response_q    <= pwdata[2:0];
        REG_OUTPUT_CONDITION:  output_condition_q  <= pwdata[3:0];
        REG_OUTPUT_POLARITY:   output_polarity_q   <= pwdata[0];
        REG_COMPARE_THRESHOLD: compare_threshold_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_index)
      REG_CHANNEL_MODE:      prdata = {30'd0, channel_mode_q};
      REG_INPUT_TYPE:        prdata = {30'd0, input_type_q};
      REG_INPUT_SENSITIVITY: prdata = {30'd0, input_sensitivity_q};
      REG_INPUT_RESPONSE:    prdata = {29'd0, input_response_q};
      REG_OUTPUT_CONDITION:  prdata = {28'd0, output_condition_q};
      REG_OUTPUT_POLARITY:   prdata = {31'd0, output_polarity_q};
      REG_COMPARE_THRESHOLD: prdata = compare_threshold_q;
      default:               prdata = '0;
    endcase
  end

  // Pipeline control
  logic    in_valid_q;
  tick_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= s_axis_tdata[113:0];
    end
  end

  // Channel state
  logic [16:0] sample_timer_q, sample_timer_d;
  logic [1:0]  previous_level_q, previous_level_d;

  // Timer step and reload period
  logic [17:0] timer_diff;
  logic        timer_expired;
  logic [16:0] reload;

  assign timer_diff    = {1'b0, sample_timer_q} - {2'b00, in_q.tick_ms};
  assign timer_expired = timer_diff[17];

  always_comb begin
    unique case (input_sensitivity_q)
      SENS_HIGH: reload = HIGH_SENS_MS;
      SENS_MID:  reload = MID_SENS_MS;
      default:   reload = LOW_SENS_MS;
    endcase
  end

  // Qualify the pin against the last sampled level
  logic qualified;

  always_comb begin
    unique case (input_type_q)
      TYPE_RISING:  qualified = in_q.pin_level && (previous_level_q == 2'd0);
      TYPE_FALLING: qualified = !in_q.pin_level && (previous_level_q == 2'd1);
      TYPE_HIGH:    qualified = in_q.pin_level;
      default:      qualified = !in_q.pin_level;
    endcase
  end

  // Select the compared quantity, then compare once
  logic [31:0] quantity;
  logic        q_gt, q_lt, q_eq, met;

  always_comb begin
    unique case (output_condition_q)
      COND_V_GT, COND_V_LT, COND_V_EQ: quantity = in_q.measured_voltage;
      COND_I_GT, COND_I_LT, COND_I_EQ: quantity = in_q.measured_current;
      default:                         quantity = in_q.measured_power;
    endcase
  end

  assign q_gt = quantity > compare_threshold_q;
  assign q_lt = quantity < compare_threshold_q;
  assign q_eq = quantity == compare_threshold_q;

  always_comb begin
    unique case (output_condition_q)
      COND_SUPPLY_OFF:                met = !in_q.supply_on;
      COND_SUPPLY_ON:                 met = in_q.supply_on;
      COND_V_GT, COND_I_GT, COND_P_GT: met = q_gt;
      COND_V_LT, COND_I_LT, COND_P_LT: met = q_lt;
      COND_V_EQ, COND_I_EQ, COND_P_EQ: met = q_eq;
      default:                        met = 1'b0;
    endcase
  end

  // Evaluate the tick
  result_t res;

  always_comb begin
    res              = '0;
    sample_timer_d   = sample_timer_q;
    previous_level_d = previous_level_q;
    priority if (channel_mode_q == MODE_INPUT) begin
      sample_timer_d = timer_diff[16:0];
      if (timer_expired) begin
        if (qualified && (input_response_q <= RESP_DELAY_STOP)) begin
          res.action_valid = 1'b1;
          res.action_code  = input_response_q;
          if (input_response_q == RESP_ON) begin
            res.supply_target = 1'b1;
          end else if (input_response_q == RESP_TOGGLE) begin
            res.supply_target = !in_q.supply_on;
          end
        end
        previous_level_d = {1'b0, in_q.pin_level};
        sample_timer_d   = reload;
      end
    end else if (channel_mode_q == MODE_OUTPUT) begin
      res.drive_valid = 1'b1;
      if (output_condition_q <= COND_P_EQ) begin
        res.drive_level = met ? output_polarity_q : !output_polarity_q;
      end
    end else begin
      res = '0;
    end
  end

  // Advance state and load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_timer_q   <= TIMER_RESET;
      previous_level_q <= LEVEL_UNKNOWN;
      out_valid_q      <= 1'b0;
    end else begin
      if (advance) begin
        sample_timer_q   <= sample_timer_d;
        previous_level_q <= previous_level_d;
        out_valid_q      <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

`ifndef SYNTH
  // A tick that moves on always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("tick advanced without a result");

  // A stalled input side means a request is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

  // Drive and action results never appear together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.drive_valid && out_q.action_valid))
    else $error("drive and action in one result");

  // Meaningless fields stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.drive_valid || !out_q.drive_level) &&
                     (out_q.action_valid ||
                      (out_q.action_code == 3'd0 && !out_q.supply_target))))
    else $error("field set without its valid flag");
`endif

endmodule
